### rtl/core/dmkt_pkg.sv
`timescale 1ns / 1ps

package dmkt_pkg;

    localparam int KEY_W            = 64;
    localparam int IN_VALUE_W       = 16;
    localparam int COUNT_W          = 13;
    localparam int COUNT_MAX        = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4093;

    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int VALUE_BITS_DEF   = 16;

    // remainder unit retires this many dividend bits per cycle while step is high
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = KEY_W / DIV_BITS_PER_STEP;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    typedef struct packed {
        logic take;
        logic div_step;
        logic clear_wr;
        logic mem_wr;
        logic mem_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic item_taken;
        logic div_last;
        logic clear_last;
        logic is_store;
        logic out_free;
    } status_t;

endpackage

### rtl/core/dmkt_if.sv
`timescale 1ns / 1ps

interface dmkt_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [dmkt_pkg::KEY_W-1:0]             grid_key;
    logic [dmkt_pkg::KEY_W-1:0]             second_key;
    logic [dmkt_pkg::KEY_W-1:0]             third_key;
    logic signed [dmkt_pkg::IN_VALUE_W-1:0] entry_value;

    modport source (
        output valid, kind, grid_key, second_key, third_key, entry_value,
        input  ready
    );
    modport sink (
        input  valid, kind, grid_key, second_key, third_key, entry_value,
        output ready
    );
endinterface

interface dmkt_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   found;
    logic signed [dmkt_pkg::IN_VALUE_W-1:0] found_value;

    modport source (
        output valid, found, found_value,
        input  ready
    );
    modport sink (
        input  valid, found, found_value,
        output ready
    );
endinterface

interface dmkt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dmkt_pkg::COUNT_W-1:0] slot_count;

    modport source (
        output valid, slot_count,
        input  ready
    );
    modport sink (
        input  valid, slot_count,
        output ready
    );
endinterface

### rtl/core/dmkt_mod_unit.sv
`timescale 1ns / 1ps

// Restoring remainder of a 64-bit key by a 13-bit divisor, several bits per cycle while step is high.
module dmkt_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dmkt_pkg::KEY_W-1:0]    dividend,
    input  logic [dmkt_pkg::COUNT_W-1:0]  divisor,
    input  logic                          step,
    output logic [dmkt_pkg::COUNT_W-1:0]  rem,
    output logic                          last
);

    localparam int CNT_W = $clog2(dmkt_pkg::DIV_STEPS);
    localparam int CW    = dmkt_pkg::COUNT_W;

    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [dmkt_pkg::KEY_W-1:0]  quo_reg;
    logic [dmkt_pkg::KEY_W-1:0]  quo_next;
    logic [CW-1:0]               rem_reg;
    logic [CW-1:0]               rem_next;
    logic [CW-1:0]               div_reg;

    always_comb
    begin
        logic [CW:0]                trial;
        logic [CW-1:0]              r;
        logic [dmkt_pkg::KEY_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int j = 0; j < dmkt_pkg::DIV_BITS_PER_STEP; j++)
        begin
            trial = {r, q[dmkt_pkg::KEY_W-1]};
            q     = {q[dmkt_pkg::KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                r = CW'(trial - {1'b0, div_reg});
            end
            else
            begin
                r = trial[CW-1:0];
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = '0;
        end
        else if (step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rem  = rem_reg;
    assign last = (cnt_reg == CNT_W'(dmkt_pkg::DIV_STEPS - 1));

    a_rem_below_divisor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step && last) |=> (rem_reg < div_reg)
    ) else $error("remainder not below divisor after last step");

endmodule

### rtl/core/dmkt_ctrl.sv
`timescale 1ns / 1ps

module dmkt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  dmkt_pkg::status_t  status,
    output dmkt_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_ACCESS = 5'b01000,
        ST_CHECK  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.item_taken)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (status.is_store)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/dmkt_datapath.sv
`timescale 1ns / 1ps

module dmkt_datapath #(
    parameter int TABLE_DEPTH = dmkt_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = dmkt_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    dmkt_cfg_if.sink           cfg,
    dmkt_req_if.sink           request,
    dmkt_rsp_if.source         response,
    input  dmkt_pkg::cmd_t     cmd,
    output dmkt_pkg::status_t  status
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CW      = dmkt_pkg::COUNT_W;
    localparam int KW      = dmkt_pkg::KEY_W;
    localparam int OW      = dmkt_pkg::IN_VALUE_W;
    localparam int WIDE_W  = (IDX_W > CW) ? IDX_W : CW;
    localparam int CAP_INT = (TABLE_DEPTH < dmkt_pkg::COUNT_MAX) ? TABLE_DEPTH
                                                                 : dmkt_pkg::COUNT_MAX;
    localparam logic [CW-1:0] DIV_CAP = CW'(CAP_INT);

    typedef struct packed {
        logic                  valid;
        logic [KW-1:0]         grid_key;
        logic [KW-1:0]         second_key;
        logic [KW-1:0]         third_key;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    logic [CW-1:0]                slot_count_reg;
    logic [CW-1:0]                divisor;
    logic                         accept;

    logic                         kind_reg;
    logic [KW-1:0]                grid_key_reg;
    logic [KW-1:0]                second_key_reg;
    logic [KW-1:0]                third_key_reg;
    logic [VALUE_BITS-1:0]        value_reg;
    logic signed [31:0]           in_value_wide;

    logic [CW-1:0]                rem;
    logic                         div_last;
    logic [WIDE_W-1:0]            rem_wide;
    logic [IDX_W-1:0]             slot_idx;

    logic [IDX_W-1:0]             clr_idx_reg;
    logic                         clear_last;

    slot_t                        mem [TABLE_DEPTH];
    slot_t                        rd_slot_reg;
    slot_t                        wr_slot;

    logic                         hit;
    logic signed [VALUE_BITS-1:0] rd_value;
    logic signed [31:0]           rd_value_wide;

    logic                         rsp_valid_reg;
    logic                         found_reg;
    logic [OW-1:0]                found_value_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= dmkt_pkg::COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            slot_count_reg <= cfg.slot_count;
        end
    end

    // zero slots act as one, more than the table holds saturate to the depth
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            divisor = CW'(1);
        end
        else if (slot_count_reg > DIV_CAP)
        begin
            divisor = DIV_CAP;
        end
        else
        begin
            divisor = slot_count_reg;
        end
    end

    // item capture
    assign request.ready = cmd.take;
    assign accept        = cmd.take && request.valid;
    assign in_value_wide = 32'(request.entry_value);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= request.kind;
            grid_key_reg   <= request.grid_key;
            second_key_reg <= request.second_key;
            third_key_reg  <= request.third_key;
            value_reg      <= in_value_wide[VALUE_BITS-1:0];
        end
    end

    dmkt_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (request.grid_key),
        .divisor  (divisor),
        .step     (cmd.div_step),
        .rem      (rem),
        .last     (div_last)
    );

    assign rem_wide = WIDE_W'(rem);
    assign slot_idx = rem_wide[IDX_W-1:0];

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
        end
    end

    assign clear_last = (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    // slot memory: one write port, one registered read port
    always_comb
    begin
        wr_slot.valid      = 1'b1;
        wr_slot.grid_key   = grid_key_reg;
        wr_slot.second_key = second_key_reg;
        wr_slot.third_key  = third_key_reg;
        wr_slot.value      = value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            mem[slot_idx] <= wr_slot;
        end
        if (cmd.mem_rd)
        begin
            rd_slot_reg <= mem[slot_idx];
        end
    end

    assign hit = rd_slot_reg.valid
              && (rd_slot_reg.grid_key == grid_key_reg)
              && (rd_slot_reg.second_key == second_key_reg)
              && (rd_slot_reg.third_key == third_key_reg);

    assign rd_value      = rd_slot_reg.value;
    assign rd_value_wide = 32'(rd_value);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg       <= hit;
            found_value_reg <= hit ? rd_value_wide[OW-1:0] : '0;
        end
    end

    assign response.valid       = rsp_valid_reg;
    assign response.found       = found_reg;
    assign response.found_value = found_value_reg;

    assign status.item_taken = accept;
    assign status.div_last   = div_last;
    assign status.clear_last = clear_last;
    assign status.is_store   = (kind_reg == dmkt_pkg::KIND_STORE);
    assign status.out_free   = !rsp_valid_reg || response.ready;

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || response.ready)
    ) else $error("result loaded over one not yet transferred");

    a_no_take_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !request.ready
    ) else $error("request taken during clearing pass");

    a_slot_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr || cmd.mem_rd) |-> (32'(slot_idx) < 32'(TABLE_DEPTH))
    ) else $error("slot index beyond table depth");

endmodule

### rtl/core/direct_mapped_key_table.sv
`timescale 1ns / 1ps

// Direct-mapped key table: each request is a store or a load carrying three
// 64-bit keys; the slot is grid_key modulo the configured slot count (zero is
// taken as one, counts above the depth saturate to it). A store writes the
// slot and returns nothing; a load returns found and the stored value, or
// found low with a zero value. An item passes through the request transfer,
// the remainder unit (4 key bits per cycle), the memory port, and for a load
// a compare of the registered read data. A load then waits while the
// previous result is still untransferred. After reset a clearing pass runs,
// one slot per cycle, during which no request is taken; slot_count writes are
// taken at any time but must only change while the block is idle.
module direct_mapped_key_table #(
    parameter int TABLE_DEPTH = dmkt_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = dmkt_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dmkt_cfg_if.sink    cfg,
    dmkt_req_if.sink    request,
    dmkt_rsp_if.source  response
);

    dmkt_pkg::cmd_t    cmd;
    dmkt_pkg::status_t status;

    dmkt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    dmkt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .request  (request),
        .response (response),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### dv/direct_mapped_key_table_checker.sv
`timescale 1ns / 1ps

module direct_mapped_key_table_checker #(
    parameter int TABLE_DEPTH = dmkt_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = dmkt_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dmkt_cfg_if  cfg,
    dmkt_req_if  request,
    dmkt_rsp_if  response,
    output int   pending,
    output int   mismatches
);

    typedef struct packed {
        logic                                   found;
        logic signed [dmkt_pkg::IN_VALUE_W-1:0] value;
    } lookup_result_t;

    logic [dmkt_pkg::COUNT_W-1:0] slot_count;
    bit                           slot_valid  [TABLE_DEPTH];
    logic [dmkt_pkg::KEY_W-1:0]   slot_grid   [TABLE_DEPTH];
    logic [dmkt_pkg::KEY_W-1:0]   slot_second [TABLE_DEPTH];
    logic [dmkt_pkg::KEY_W-1:0]   slot_third  [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]        slot_value  [TABLE_DEPTH];
    lookup_result_t               lookups [$];

    initial mismatches = 0;

    // zero counts as one slot, anything above the depth saturates to it
    function automatic int unsigned slot_index(input logic [dmkt_pkg::KEY_W-1:0] key);
        logic [dmkt_pkg::KEY_W-1:0] divisor;
        if (slot_count == '0)
            divisor = dmkt_pkg::KEY_W'(1);
        else if (32'(slot_count) > TABLE_DEPTH)
            divisor = dmkt_pkg::KEY_W'(TABLE_DEPTH);
        else
            divisor = dmkt_pkg::KEY_W'(slot_count);
        return 32'(key % divisor);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned    s;
        lookup_result_t want;
        if (!rst_n)
        begin
            slot_count = dmkt_pkg::COUNT_RESET;
            foreach (slot_valid[i])
                slot_valid[i] = 1'b0;
            lookups.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                slot_count = cfg.slot_count;

            if (response.valid && response.ready)
            begin
                if (lookups.size() == 0)
                begin
                    report_mismatch($sformatf("result with no lookup pending (found %0b value %0d)",
                                              response.found, response.found_value));
                end
                else
                begin
                    want = lookups.pop_front();
                    if (response.found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  response.found, want.found));
                    if (response.found_value !== want.value)
                        report_mismatch($sformatf("found_value %0d, expected %0d",
                                                  response.found_value, want.value));
                end
            end

            if (request.valid && request.ready)
            begin
                s = slot_index(request.grid_key);
                if (request.kind == dmkt_pkg::KIND_STORE)
                begin
                    slot_valid[s]  = 1'b1;
                    slot_grid[s]   = request.grid_key;
                    slot_second[s] = request.second_key;
                    slot_third[s]  = request.third_key;
                    slot_value[s]  = VALUE_BITS'(request.entry_value);
                end
                else
                begin
                    if (slot_valid[s] && slot_grid[s] == request.grid_key &&
                        slot_second[s] == request.second_key &&
                        slot_third[s] == request.third_key)
                    begin
                        want.found = 1'b1;
                        want.value = dmkt_pkg::IN_VALUE_W'($signed(slot_value[s]));
                    end
                    else
                    begin
                        want = '0;
                    end
                    lookups.push_back(want);
                end
            end
        end
        pending = lookups.size();
    end

endmodule

### dv/direct_mapped_key_table_test.sv
`timescale 1ns / 1ps

module direct_mapped_key_table_test;

    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 175;
    localparam int POOL_MAX      = 48;
    localparam int IDLE_PERCENT  = 37;

    localparam logic [dmkt_pkg::KEY_W-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [dmkt_pkg::KEY_W-1:0] KEY_B = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        logic [dmkt_pkg::KEY_W-1:0] grid;
        logic [dmkt_pkg::KEY_W-1:0] second;
        logic [dmkt_pkg::KEY_W-1:0] third;
    } key_triple_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        steady = 1'b0;
    int          pending;
    int          mismatches;
    int          stall_cycles = 0;
    key_triple_t stored_keys [$];

    logic [dmkt_pkg::COUNT_W-1:0] count_plan [8] = '{13'd5, 13'd0, 13'd4096, 13'd8191,
                                                     13'd1, 13'd7, 13'd4099, 13'd4093};

    dmkt_req_if req_ch ();
    dmkt_rsp_if rsp_ch ();
    dmkt_cfg_if cfg_ch ();

    direct_mapped_key_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .request  (req_ch),
        .response (rsp_ch)
    );

    direct_mapped_key_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .request    (req_ch),
        .response   (rsp_ch),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("direct_mapped_key_table_test: FAIL");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [dmkt_pkg::KEY_W-1:0] rand_key();
        if ($urandom_range(9) < 3)
            return dmkt_pkg::KEY_W'($urandom_range(20000));
        return {$urandom, $urandom};
    endfunction

    // entered and left at a falling edge; valid stays high into the next item
    task automatic send_item(input logic kind, input key_triple_t keys,
                             input logic signed [dmkt_pkg::IN_VALUE_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.grid_key    <= keys.grid;
        req_ch.second_key  <= keys.second;
        req_ch.third_key   <= keys.third;
        req_ch.entry_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_direct(input logic kind, input logic [dmkt_pkg::KEY_W-1:0] grid,
                               input logic [dmkt_pkg::KEY_W-1:0] second,
                               input logic [dmkt_pkg::KEY_W-1:0] third,
                               input logic signed [dmkt_pkg::IN_VALUE_W-1:0] value);
        key_triple_t keys;
        keys.grid   = grid;
        keys.second = second;
        keys.third  = third;
        send_item(kind, keys, value);
    endtask

    // drain results, then hold long enough for a trailing store to finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_slot_count(input logic [dmkt_pkg::COUNT_W-1:0] count);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.slot_count <= count;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly stores and loads of recently stored keys, some near misses and noise
    task automatic random_item();
        int                                     roll;
        key_triple_t                            keys;
        logic signed [dmkt_pkg::IN_VALUE_W-1:0] value;
        roll  = $urandom_range(99);
        value = dmkt_pkg::IN_VALUE_W'($urandom);
        if (roll < 35 || stored_keys.size() == 0)
        begin
            keys.grid   = rand_key();
            keys.second = rand_key();
            keys.third  = rand_key();
            stored_keys.push_back(keys);
            if (stored_keys.size() > POOL_MAX)
                void'(stored_keys.pop_front());
            send_item(dmkt_pkg::KIND_STORE, keys, value);
        end
        else if (roll < 90)
        begin
            keys = stored_keys[$urandom_range(stored_keys.size() - 1)];
            if (roll >= 78)
            begin
                case ($urandom_range(2))
                    0: keys.grid   ^= 64'd1 << $urandom_range(63);
                    1: keys.second ^= 64'd1 << $urandom_range(63);
                    default: keys.third ^= 64'd1 << $urandom_range(63);
                endcase
            end
            send_item(dmkt_pkg::KIND_LOAD, keys, value);
        end
        else
        begin
            keys.grid   = rand_key();
            keys.second = rand_key();
            keys.third  = rand_key();
            send_item(dmkt_pkg::KIND_LOAD, keys, value);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = dmkt_pkg::KIND_LOAD;
        req_ch.grid_key      = '0;
        req_ch.second_key    = '0;
        req_ch.third_key     = '0;
        req_ch.entry_value   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.slot_count    = dmkt_pkg::COUNT_RESET;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset slot count, so grid keys 5 and 4098 share a slot
        send_direct(dmkt_pkg::KIND_LOAD,  '0, '0, '0, 16'sd0);
        send_direct(dmkt_pkg::KIND_STORE, '0, '0, '0, -16'sd32768);
        send_direct(dmkt_pkg::KIND_LOAD,  '0, '0, '0, 16'sd0);
        send_direct(dmkt_pkg::KIND_STORE, '1, '1, '1, 16'sd32767);
        send_direct(dmkt_pkg::KIND_LOAD,  '1, '1, '1, -16'sd1);
        send_direct(dmkt_pkg::KIND_STORE, 64'd5, KEY_A, KEY_B, -16'sd1);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd5, KEY_A ^ 64'd1, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd5, KEY_A, KEY_B ^ (64'd1 << 63), 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd4098, KEY_A, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd5, KEY_A, KEY_B, 16'sd123);
        send_direct(dmkt_pkg::KIND_STORE, 64'd4098, KEY_A, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd5, KEY_A, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd4098, KEY_A, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_LOAD,  64'd1, KEY_A, KEY_B, 16'sd0);
        send_direct(dmkt_pkg::KIND_STORE, KEY_B, KEY_A, '0, 16'sd1);
        send_direct(dmkt_pkg::KIND_LOAD,  KEY_B, KEY_A, '0, 16'sd0);

        foreach (count_plan[p])
        begin
            settle();
            write_slot_count(count_plan[p]);
            steady <= (p == 2);
            repeat (PHASE_ITEMS) random_item();
        end
        steady <= 1'b0;
        settle();

        if (mismatches == 0)
            $display("direct_mapped_key_table_test: PASS");
        else
            $display("direct_mapped_key_table_test: FAIL");
        $finish;
    end

endmodule
